### sv/shift_and_literal_search_defines.svh
// Assertion macros shared by the shift-and literal search RTL
`ifndef SHIFT_AND_LITERAL_SEARCH_DEFINES_SVH
`define SHIFT_AND_LITERAL_SEARCH_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define SLAS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define SLAS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### sv/slas_pkg.sv
// Shared constants and types for the shift-and literal search block
package slas_pkg;

	localparam int NEEDLE_CAP      = 16;
	localparam int LANES_MAX       = 8;
	localparam int DEF_LANES       = 8;
	localparam int DEF_MAX_NEEDLE  = 16;
	localparam int DEF_OFFSET_BITS = 32;
	localparam int OFFSET_OUT_W    = 32;
	localparam int CHUNK_W         = 64;
	localparam int COUNT_W         = 4;
	localparam int LEN_W           = 5;
	localparam int IN_TDATA_W      = 72;

	typedef enum logic [1:0] {
		CFG_NEEDLE_LO = 2'd0,
		CFG_NEEDLE_HI = 2'd1,
		CFG_NEEDLE_LEN = 2'd2
	} cfg_idx_t;

	typedef struct packed {
		logic       found;
		logic [2:0] lane;
		logic [3:0] used;
	} merge_stat_t;

endpackage

### sv/slas_lane.sv
// One byte lane: compares a haystack byte against every needle byte
module slas_lane import slas_pkg::*; #(
	parameter int NW = DEF_MAX_NEEDLE
) (
	input  logic                    clk,
	input  logic                    en,
	input  logic [7:0]              hay_byte,
	input  logic [2*CHUNK_W-1:0]    needle,
	output logic [NW-1:0]           eq_s1
);

	logic [NW-1:0] eq;

	always_comb begin
		for (int j = 0; j < NW; j++) begin
			eq[j] = (needle[j*8 +: 8] == hay_byte);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			eq_s1 <= eq;
		end
	end

endmodule

### sv/slas_merge.sv
// Merges the lane compares into the prefix vector and finds the first match
module slas_merge import slas_pkg::*; #(
	parameter int LANES = DEF_LANES,
	parameter int NW    = DEF_MAX_NEEDLE
) (
	input  logic [NW-1:0]    pv_in,
	input  logic [NW-1:0]    eq [LANES],
	input  logic [LANES-1:0] act,
	input  logic [NW-1:0]    lenmask,
	input  logic [NW-1:0]    topbit,
	output logic [NW-1:0]    pv_out,
	output merge_stat_t      stat
);

	logic [NW-1:0] pv;
	logic          done;

	always_comb begin
		pv   = pv_in;
		stat = '0;
		done = 1'b0;
		for (int k = 0; k < LANES; k++) begin
			if (act[k] && !done) begin
				pv        = ((pv << 1) | NW'(1)) & eq[k] & lenmask;
				stat.used = stat.used + 4'd1;
				if ((pv & topbit) != '0) begin
					done       = 1'b1;
					stat.found = 1'b1;
					stat.lane  = 3'(k);
				end
			end
		end
		pv_out = pv;
	end

endmodule

### sv/shift_and_literal_search.sv
// Top level of the shift-and literal search block
//
// Haystack chunks arrive on the s_axis channel: tdata holds up to eight bytes
// (earliest byte lowest) and a byte count, tlast marks the final chunk of a
// haystack. The needle is loaded over the cfg channel (index 0 and 1: needle
// bytes, index 2: needle length), which is always ready; write it between
// haystacks or while nothing is in flight.
// One result per haystack leaves on m_axis: tuser set with the start offset of
// the leftmost match in tdata, sent as soon as the chunk holding the match end
// is scanned, or tuser clear with zero data when the last chunk passes with no
// match. Bytes after a match are dropped until the last chunk.
// Throughput is one chunk per cycle unless m_axis stalls; a chunk passes through the
// stage-one register and then the output register before its result is valid.
// Stage one registers the per-lane byte compares, stage two runs the
// eight-lane shift-and chain against the held prefix vector.
// When m_axis stalls, one result waits in the output register and one chunk
// in stage one; s_axis drops ready only while both are held.
// Reset clears the prefix vector, byte position and match flag, sets the
// needle to zeros with length one, and empties both stages.
module shift_and_literal_search import slas_pkg::*; #(
	parameter int LANES       = DEF_LANES,
	parameter int MAX_NEEDLE  = DEF_MAX_NEEDLE,
	parameter int OFFSET_BITS = DEF_OFFSET_BITS
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    s_axis_tvalid,
	output logic                    s_axis_tready,
	input  logic [IN_TDATA_W-1:0]   s_axis_tdata,  // chunk_bytes[63:0], byte_count[67:64]
	input  logic                    s_axis_tlast,  // last_chunk
	output logic                    m_axis_tvalid,
	input  logic                    m_axis_tready,
	output logic [OFFSET_OUT_W-1:0] m_axis_tdata,  // match_offset[31:0]
	output logic                    m_axis_tuser,  // found
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [1:0]              cfg_index,
	input  logic [CHUNK_W-1:0]      cfg_data
);

	`include "shift_and_literal_search_defines.svh"

	localparam int NW = (MAX_NEEDLE < NEEDLE_CAP) ? MAX_NEEDLE : NEEDLE_CAP;
	localparam int OW = OFFSET_BITS;

	logic [CHUNK_W-1:0]     needle_lo_q;
	logic [CHUNK_W-1:0]     needle_hi_q;
	logic [LEN_W-1:0]       len_q;
	logic [NW-1:0]          pv_q;
	logic [OW-1:0]          bytes_q;
	logic                   reported_q;

	logic                   valid_s1;
	logic                   last_s1;
	logic [LANES-1:0]       cnt_ok_s1;
	logic [NW-1:0]          eq_s1 [LANES];

	logic                   out_valid_q;
	logic                   out_found_q;
	logic [OFFSET_OUT_W-1:0] out_off_q;

	logic                   fire1;
	logic                   fire2;
	logic [COUNT_W-1:0]     cnt_in;
	logic [LEN_W-1:0]       len_eff;
	logic [NW-1:0]          lenmask;
	logic [NW-1:0]          topbit;
	logic [OW-1:0]          avail;
	logic [LANES-1:0]       act;
	logic [NW-1:0]          pv_n;
	merge_stat_t            stat;
	logic [OW-1:0]          start;
	logic [OW+OFFSET_OUT_W-1:0] start_wide;
	logic                   res_valid;

	assign cfg_ready     = 1'b1;
	assign cnt_in        = s_axis_tdata[CHUNK_W +: COUNT_W];
	assign fire2         = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || fire2;
	assign fire1         = s_axis_tvalid && s_axis_tready;

	always_comb begin
		if (len_q == '0) begin
			len_eff = LEN_W'(1);
		end else if (len_q > LEN_W'(NW)) begin
			len_eff = LEN_W'(NW);
		end else begin
			len_eff = len_q;
		end
		for (int j = 0; j < NW; j++) begin
			lenmask[j] = (LEN_W'(j) < len_eff);
			topbit[j]  = (LEN_W'(j) == len_eff - LEN_W'(1));
		end
	end

	genvar g;
	generate
		for (g = 0; g < LANES; g++) begin : g_lane
			slas_lane #(.NW(NW)) u_lane (
				.clk      (clk),
				.en       (fire1),
				.hay_byte (s_axis_tdata[g*8 +: 8]),
				.needle   ({needle_hi_q, needle_lo_q}),
				.eq_s1    (eq_s1[g])
			);
		end
	endgenerate

	assign avail = ~bytes_q;

	always_comb begin
		for (int k = 0; k < LANES; k++) begin
			act[k] = cnt_ok_s1[k] && !reported_q && (avail > OW'(k));
		end
	end

	slas_merge #(.LANES(LANES), .NW(NW)) u_merge (
		.pv_in   (pv_q),
		.eq      (eq_s1),
		.act     (act),
		.lenmask (lenmask),
		.topbit  (topbit),
		.pv_out  (pv_n),
		.stat    (stat)
	);

	assign start      = bytes_q + OW'(stat.lane) + OW'(1) - OW'(len_eff);
	assign start_wide = {{OFFSET_OUT_W{1'b0}}, start};
	assign res_valid  = stat.found || (last_s1 && !reported_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			needle_lo_q <= '0;
			needle_hi_q <= '0;
			len_q       <= LEN_W'(1);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_NEEDLE_LO:  needle_lo_q <= cfg_data;
				CFG_NEEDLE_HI:  needle_hi_q <= cfg_data;
				CFG_NEEDLE_LEN: len_q       <= cfg_data[LEN_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (fire1) begin
			last_s1 <= s_axis_tlast;
			for (int k = 0; k < LANES; k++) begin
				cnt_ok_s1[k] <= (cnt_in > COUNT_W'(k));
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pv_q       <= '0;
			bytes_q    <= '0;
			reported_q <= 1'b0;
		end else if (fire2) begin
			if (last_s1) begin
				pv_q       <= '0;
				bytes_q    <= '0;
				reported_q <= 1'b0;
			end else begin
				pv_q       <= pv_n;
				bytes_q    <= bytes_q + OW'(stat.used);
				reported_q <= reported_q || stat.found;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire2 && res_valid) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire2 && res_valid) begin
			out_found_q <= stat.found;
			out_off_q   <= stat.found ? start_wide[OFFSET_OUT_W-1:0] : '0;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_off_q;
	assign m_axis_tuser  = out_found_q;

	`SLAS_ASSERT_NEXT(a_match_sets_flag, fire2 && stat.found && !last_s1, reported_q, "match did not set reported flag")
	`SLAS_ASSERT_NEXT(a_last_clears, fire2 && last_s1, pv_q == '0 && bytes_q == '0 && !reported_q, "last chunk did not clear state")
	`SLAS_ASSERT_NOW(a_miss_zero, m_axis_tvalid && !m_axis_tuser, m_axis_tdata == '0, "not-found result carries nonzero offset")
	`SLAS_ASSERT_NOW(a_no_second_hit, fire2 && reported_q, !stat.found, "second match reported in one haystack")

endmodule
